// ===== hdl/mcsm_pkg.sv =====
// Types and constants shared by the MIDI control switch mapper.
// No dependencies.
package mcsm_pkg;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_IS_NOTE   = 4'd0,
    REG_MATCH_NUMBER     = 4'd1,
    REG_CHANNEL_FILTER   = 4'd2,
    REG_THRESHOLD        = 4'd3,
    REG_EQUALS_MODE      = 4'd4,
    REG_INVERSE_SENSE    = 4'd5,
    REG_MOMENTARY        = 4'd6,
    REG_TARGET_IS_SWITCH = 4'd7
  } reg_index_t;

  localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
  localparam logic [3:0] KIND_CONTROLLER = 4'hB;

  localparam logic [6:0] LEVEL_ON        = 7'd127;
  localparam logic [6:0] LEVEL_OFF       = 7'd0;
  localparam logic [6:0] THRESHOLD_RESET = 7'd64;
  localparam logic [4:0] CHANNEL_MAX     = 5'd16;

  typedef struct packed {
    logic       source_is_note;
    logic [6:0] match_number;
    logic [4:0] channel_filter;
    logic [6:0] threshold;
    logic       equals_mode;
    logic       inverse_sense;
    logic       momentary;
    logic       target_is_switch;
  } cfg_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } item_t;

  typedef struct packed {
    logic [6:0] level;
    logic       switch_on;
    logic       for_switch;
  } result_t;

  typedef struct packed {
    logic    hit;
    result_t result;
  } map_out_t;

endpackage

// ===== hdl/mcsm_if.sv =====
// Request channels of the MIDI control switch mapper: message in, result out.
// No dependencies.
interface mcsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] status;
  logic [6:0] data_first;
  logic [6:0] data_second;

  modport source(output valid, status, data_first, data_second, input ready);
  modport sink(input valid, status, data_first, data_second, output ready);
endinterface

interface mcsm_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] level;
  logic       switch_on;
  logic       for_switch;

  modport source(output valid, level, switch_on, for_switch, input ready);
  modport sink(input valid, level, switch_on, for_switch, output ready);
endinterface

// ===== hdl/mcsm_cfg_regs.sv =====
// Configuration register file of the MIDI control switch mapper.
// Depends on mcsm_pkg.
module mcsm_cfg_regs import mcsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_is_note   <= 1'b0;
      cfg.match_number     <= 7'd0;
      cfg.channel_filter   <= 5'd0;
      cfg.threshold        <= THRESHOLD_RESET;
      cfg.equals_mode      <= 1'b0;
      cfg.inverse_sense    <= 1'b0;
      cfg.momentary        <= 1'b0;
      cfg.target_is_switch <= 1'b1;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SOURCE_IS_NOTE:   cfg.source_is_note   <= cfg_data[0];
        REG_MATCH_NUMBER:     cfg.match_number     <= cfg_data[6:0];
        REG_CHANNEL_FILTER:   cfg.channel_filter   <= cfg_data[4:0];
        REG_THRESHOLD:        cfg.threshold        <= cfg_data[6:0];
        REG_EQUALS_MODE:      cfg.equals_mode      <= cfg_data[0];
        REG_INVERSE_SENSE:    cfg.inverse_sense    <= cfg_data[0];
        REG_MOMENTARY:        cfg.momentary        <= cfg_data[0];
        REG_TARGET_IS_SWITCH: cfg.target_is_switch <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/mcsm_map.sv =====
// Message filter, switch decision and switch state of the mapper.
// Depends on mcsm_pkg.
module mcsm_map import mcsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  item_t    item,
  input  logic     fire,
  output map_out_t map_out
);

  logic [6:0] last_value, last_value_next;
  logic       crossing_state, crossing_state_next;
  logic       note_state, note_state_next;

  logic [3:0] kind;
  logic [4:0] chan_sel;
  logic [4:0] chan_msg;
  logic       chan_ok;
  logic       is_on;
  logic       is_off;
  logic [6:0] thr_eff;
  logic       sw_on;

  assign kind     = item.status[7:4];
  assign chan_sel = (cfg.channel_filter > CHANNEL_MAX) ? CHANNEL_MAX : cfg.channel_filter;
  assign chan_msg = {1'b0, item.status[3:0]} + 5'd1;
  assign chan_ok  = (chan_sel == 5'd0) || (chan_msg == chan_sel);
  assign is_on    = (kind == KIND_NOTE_ON) && (item.data_second != 7'd0);
  assign is_off   = (kind == KIND_NOTE_OFF) ||
                    ((kind == KIND_NOTE_ON) && (item.data_second == 7'd0));
  assign thr_eff  = (cfg.threshold == 7'd0) ? 7'd1 : cfg.threshold;

  always_comb begin
    last_value_next     = last_value;
    crossing_state_next = crossing_state;
    note_state_next     = note_state;
    map_out             = '0;
    sw_on               = 1'b0;
    if ((item.data_first == cfg.match_number) && chan_ok) begin
      if (cfg.source_is_note) begin
        if (cfg.momentary) begin
          if (is_on || is_off) begin
            note_state_next = cfg.inverse_sense ? is_off : is_on;
            map_out.hit     = 1'b1;
          end
        end else if (is_on) begin
          note_state_next = ~note_state;
          map_out.hit     = 1'b1;
        end
        map_out.result.level      = note_state_next ? LEVEL_ON : LEVEL_OFF;
        map_out.result.switch_on  = cfg.target_is_switch & note_state_next;
        map_out.result.for_switch = cfg.target_is_switch;
      end else if (kind == KIND_CONTROLLER) begin
        last_value_next = item.data_second;
        if (!cfg.target_is_switch) begin
          map_out.hit          = 1'b1;
          map_out.result.level = item.data_second;
        end else begin
          if (cfg.equals_mode) begin
            if (item.data_second == cfg.threshold) begin
              crossing_state_next = ~crossing_state;
            end
          end else if ((last_value < thr_eff) && (item.data_second >= thr_eff)) begin
            crossing_state_next = 1'b1;
          end else if ((last_value >= thr_eff) && (item.data_second < thr_eff)) begin
            crossing_state_next = 1'b0;
          end
          sw_on = (cfg.equals_mode || !cfg.inverse_sense) ? crossing_state_next
                                                           : ~crossing_state_next;
          map_out.hit               = crossing_state_next != crossing_state;
          map_out.result.level      = sw_on ? LEVEL_ON : LEVEL_OFF;
          map_out.result.switch_on  = sw_on;
          map_out.result.for_switch = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_value     <= 7'd0;
      crossing_state <= 1'b1;
      note_state     <= 1'b0;
    end else if (fire) begin
      last_value     <= last_value_next;
      crossing_state <= crossing_state_next;
      note_state     <= note_state_next;
    end
  end

endmodule

// ===== hdl/midi_control_switch_mapper.sv =====
// Top level of the MIDI control switch mapper: message register, mapper, result register.
// Depends on mcsm_pkg, mcsm_if, mcsm_cfg_regs and mcsm_map.
//
//  channel  direction  payload                              handshake
//  msg      in         status, data_first, data_second      valid / ready
//  res      out        level, switch_on, for_switch         valid / ready
//  cfg      in         cfg_index, cfg_data                  cfg_write
//
// One message is taken per cycle unless a stalled result holds the message register;
// a result passes from the message register through the mapper to the result register.
// The rate is set by the message register feeding the mapper state in one pass.
// Messages that give no result retire without waiting on the result register.
// A stalled result holds and backs up the message register only if another result follows.
// rst clears the configuration to its defaults, the switch state and both valid flags.
module midi_control_switch_mapper import mcsm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mcsm_in_if.sink                msg,
  mcsm_out_if.source             res
);

  cfg_t     cfg;
  item_t    stage;
  logic     stage_valid;
  map_out_t map_out;
  result_t  res_data;
  logic     res_free;
  logic     advance;

  mcsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcsm_map u_map (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (stage),
    .fire    (advance),
    .map_out (map_out)
  );

  assign res_free  = !res.valid || res.ready;
  assign advance   = stage_valid && (!map_out.hit || res_free);
  assign msg.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (msg.ready) begin
      stage_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      stage <= '{status: msg.status, data_first: msg.data_first,
                 data_second: msg.data_second};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance && map_out.hit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && map_out.hit) begin
      res_data <= map_out.result;
    end
  end

  assign res.level      = res_data.level;
  assign res.switch_on  = res_data.switch_on;
  assign res.for_switch = res_data.for_switch;

endmodule

// ===== hdl/mcsm_checker.sv =====
// Port-level checks for the MIDI control switch mapper, bound to the top level.
// Depends on midi_control_switch_mapper.
module mcsm_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [6:0] res_level,
  input logic       res_switch_on,
  input logic       res_for_switch
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_level) && $stable(res_switch_on) &&
                                $stable(res_for_switch))
    else $error("stalled result changed");

  a_param_no_switch: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_for_switch |-> !res_switch_on)
    else $error("parameter result carries switch_on");

  a_switch_level: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_for_switch |->
      (res_switch_on && res_level == 7'd127) || (!res_switch_on && res_level == 7'd0))
    else $error("switch result level disagrees with switch_on");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind midi_control_switch_mapper mcsm_port_checker u_mcsm_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_level      (res.level),
  .res_switch_on  (res.switch_on),
  .res_for_switch (res.for_switch)
);

// ===== dv/mcsm_checker.sv =====
// Checker for the MIDI control switch mapper: mirrors the configuration writes,
// predicts each result of an accepted request and compares it with the result channel.
// Depends on mcsm_pkg and mcsm_if.
module mcsm_checker import mcsm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mcsm_in_if                     msg,
  mcsm_out_if                    res,
  output int                     fail_count,
  output int                     pending,
  output int                     results_checked
);

  cfg_t       cfg;
  logic [6:0] last_value;
  logic       crossing_state;
  logic       note_state;
  result_t    due_results[$];
  result_t    got;
  result_t    want;
  result_t    mapped;
  int         fails = 0;
  int         checked = 0;

  function automatic bit map_message(input item_t m, output result_t r);
    logic [3:0] kind;
    logic [4:0] chan_sel;
    logic [6:0] thr;
    logic       was;
    logic       is_on;
    logic       is_off;
    logic       on;
    kind = m.status[7:4];
    chan_sel = (cfg.channel_filter > CHANNEL_MAX) ? CHANNEL_MAX : cfg.channel_filter;
    r = '0;
    if (m.data_first != cfg.match_number) return 1'b0;
    if (chan_sel != 5'd0 && ({1'b0, m.status[3:0]} + 5'd1) != chan_sel) return 1'b0;
    if (cfg.source_is_note) begin
      is_on = (kind == KIND_NOTE_ON) && (m.data_second != 7'd0);
      is_off = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && (m.data_second == 7'd0));
      if (cfg.momentary) begin
        if (!is_on && !is_off) return 1'b0;
        note_state = cfg.inverse_sense ? is_off : is_on;
      end else begin
        if (!is_on) return 1'b0;
        note_state = ~note_state;
      end
      r.level = note_state ? LEVEL_ON : LEVEL_OFF;
      r.switch_on = cfg.target_is_switch ? note_state : 1'b0;
      r.for_switch = cfg.target_is_switch;
      return 1'b1;
    end
    if (kind != KIND_CONTROLLER) return 1'b0;
    if (!cfg.target_is_switch) begin
      last_value = m.data_second;
      r.level = m.data_second;
      return 1'b1;
    end
    was = crossing_state;
    if (cfg.equals_mode) begin
      if (m.data_second == cfg.threshold) crossing_state = ~crossing_state;
    end else begin
      thr = (cfg.threshold == 7'd0) ? 7'd1 : cfg.threshold;
      if (last_value < thr && m.data_second >= thr) crossing_state = 1'b1;
      else if (last_value >= thr && m.data_second < thr) crossing_state = 1'b0;
    end
    last_value = m.data_second;
    if (crossing_state == was) return 1'b0;
    on = (cfg.equals_mode || !cfg.inverse_sense) ? crossing_state : ~crossing_state;
    r.level = on ? LEVEL_ON : LEVEL_OFF;
    r.switch_on = on;
    r.for_switch = 1'b1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg = '{1'b0, 7'd0, 5'd0, THRESHOLD_RESET, 1'b0, 1'b0, 1'b0, 1'b1};
      last_value = 7'd0;
      crossing_state = 1'b1;
      note_state = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SOURCE_IS_NOTE:   cfg.source_is_note = cfg_data[0];
          REG_MATCH_NUMBER:     cfg.match_number = cfg_data[6:0];
          REG_CHANNEL_FILTER:   cfg.channel_filter = cfg_data[4:0];
          REG_THRESHOLD:        cfg.threshold = cfg_data[6:0];
          REG_EQUALS_MODE:      cfg.equals_mode = cfg_data[0];
          REG_INVERSE_SENSE:    cfg.inverse_sense = cfg_data[0];
          REG_MOMENTARY:        cfg.momentary = cfg_data[0];
          REG_TARGET_IS_SWITCH: cfg.target_is_switch = cfg_data[0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        got = '{res.level, res.switch_on, res.for_switch};
        if (due_results.size() == 0) begin
          $error("unexpected result: level %0d switch_on %0d for_switch %0d",
                 got.level, got.switch_on, got.for_switch);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (got.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, got.level);
            fails++;
          end
          if (got.switch_on !== want.switch_on) begin
            $error("switch_on: expected %0d, actual %0d", want.switch_on, got.switch_on);
            fails++;
          end
          if (got.for_switch !== want.for_switch) begin
            $error("for_switch: expected %0d, actual %0d", want.for_switch, got.for_switch);
            fails++;
          end
          checked++;
        end
      end
      if (msg.valid && msg.ready) begin
        if (map_message(item_t'{msg.status, msg.data_first, msg.data_second}, mapped))
          due_results.push_back(mapped);
      end
    end
    fail_count <= fails;
    pending <= due_results.size();
    results_checked <= checked;
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the MIDI control switch mapper: clock, reset, configuration phases,
// directed and random requests under varied idling, and the verdict.
// Depends on mcsm_pkg, mcsm_if, midi_control_switch_mapper and mcsm_checker.
module tb_top;
  import mcsm_pkg::*;

  localparam int         QUIET_LIMIT    = 2000;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         RANDOM_PHASES  = 16;
  localparam logic [3:0] KIND_PITCH_BEND = 4'hE;
  localparam logic [3:0] KIND_SYSTEM    = 4'hF;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;
  int                     results_checked;
  int                     send_idle_pct = 0;
  int                     stall_pct = 0;
  int                     sent_count = 0;
  int                     phase_count = 0;
  int                     quiet_cycles = 0;

  mcsm_in_if  msg_ch();
  mcsm_out_if res_ch();

  midi_control_switch_mapper u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg       (msg_ch),
    .res       (res_ch)
  );

  mcsm_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .msg             (msg_ch),
    .res             (res_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) res_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(input logic [3:0] kind, input logic [3:0] chan,
                      input logic [6:0] num, input logic [6:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.status <= {kind, chan};
    msg_ch.data_first <= num;
    msg_ch.data_second <= val;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain(input int extra);
    msg_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_SOURCE_IS_NOTE, {6'($urandom), c.source_is_note});
    write_reg(REG_MATCH_NUMBER, c.match_number);
    write_reg(REG_CHANNEL_FILTER, {2'($urandom), c.channel_filter});
    write_reg(REG_THRESHOLD, c.threshold);
    write_reg(REG_EQUALS_MODE, {6'($urandom), c.equals_mode});
    write_reg(REG_INVERSE_SENSE, {6'($urandom), c.inverse_sense});
    write_reg(REG_MOMENTARY, {6'($urandom), c.momentary});
    write_reg(REG_TARGET_IS_SWITCH, {6'($urandom), c.target_is_switch});
    write_reg(CFG_INDEX_W'($urandom_range(8, 15)), 7'($urandom));
    cfg_write <= 1'b0;
    phase_count++;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.source_is_note = 1'($urandom);
    c.match_number = 7'($urandom);
    c.channel_filter = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom);
    c.threshold = 7'($urandom);
    c.equals_mode = 1'($urandom);
    c.inverse_sense = 1'($urandom);
    c.momentary = 1'($urandom);
    c.target_is_switch = 1'($urandom);
    case ($urandom_range(5))
      0: c.threshold = 7'd0;
      1: c.threshold = 7'd1;
      2: c.threshold = 7'd127;
      default: ;
    endcase
    case ($urandom_range(5))
      0: c.match_number = 7'd0;
      1: c.match_number = 7'd127;
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_random(input cfg_t c);
    logic [3:0] kind;
    logic [3:0] chan;
    logic [4:0] chan_sel;
    logic [6:0] num;
    logic [6:0] val;
    kind = 4'($urandom);
    chan = 4'($urandom);
    num = 7'($urandom);
    val = 7'($urandom);
    if ($urandom_range(99) >= 25) begin
      chan_sel = (c.channel_filter > CHANNEL_MAX) ? CHANNEL_MAX : c.channel_filter;
      if (chan_sel != 5'd0 && $urandom_range(9) != 0) chan = 4'(chan_sel - 5'd1);
      if (c.source_is_note) kind = ($urandom_range(2) == 0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
      else kind = KIND_CONTROLLER;
      if ($urandom_range(19) == 0) kind = 4'($urandom);
      if ($urandom_range(19) != 0) num = c.match_number;
      case ($urandom_range(3))
        0: val = c.threshold;
        1: val = c.threshold - 7'd1;
        2: val = 7'd0;
        default: ;
      endcase
    end
    send(kind, chan, num, val);
  endtask

  initial begin
    cfg_t c;
    int   n;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    msg_ch.valid <= 1'b0;
    msg_ch.status <= '0;
    msg_ch.data_first <= '0;
    msg_ch.data_second <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(KIND_CONTROLLER, 4'd0, 7'd0, 7'd127);
    send(KIND_CONTROLLER, 4'd0, 7'd0, 7'd0);
    send(KIND_CONTROLLER, 4'd0, 7'd0, 7'd64);
    send(KIND_CONTROLLER, 4'd0, 7'd0, 7'd63);
    send(KIND_CONTROLLER, 4'hF, 7'd0, 7'd127);
    send(KIND_CONTROLLER, 4'd0, 7'd1, 7'd0);
    send(KIND_NOTE_ON, 4'd0, 7'd0, 7'd0);
    send(KIND_SYSTEM, 4'hF, 7'd127, 7'd127);
    drain(SETTLE_CYCLES);

    apply_settings('{1'b0, 7'd127, 5'd31, 7'd0, 1'b0, 1'b1, 1'b0, 1'b1});
    send(KIND_CONTROLLER, 4'hF, 7'd127, 7'd0);
    send(KIND_CONTROLLER, 4'hF, 7'd127, 7'd1);
    send(KIND_CONTROLLER, 4'd0, 7'd127, 7'd0);
    send(KIND_CONTROLLER, 4'hF, 7'd127, 7'd0);
    drain(SETTLE_CYCLES);

    apply_settings('{1'b0, 7'd5, 5'd1, 7'd127, 1'b1, 1'b1, 1'b0, 1'b1});
    send(KIND_CONTROLLER, 4'd0, 7'd5, 7'd127);
    send(KIND_CONTROLLER, 4'd0, 7'd5, 7'd127);
    send(KIND_CONTROLLER, 4'd1, 7'd5, 7'd127);
    send(KIND_CONTROLLER, 4'd0, 7'd5, 7'd0);
    drain(SETTLE_CYCLES);

    apply_settings('{1'b0, 7'd0, 5'd0, 7'd64, 1'b0, 1'b0, 1'b0, 1'b0});
    send(KIND_CONTROLLER, 4'd0, 7'd0, 7'd0);
    send(KIND_CONTROLLER, 4'd3, 7'd0, 7'd127);
    drain(SETTLE_CYCLES);

    apply_settings('{1'b1, 7'd127, 5'd16, 7'd64, 1'b0, 1'b0, 1'b0, 1'b1});
    send(KIND_NOTE_ON, 4'hF, 7'd127, 7'd127);
    send(KIND_NOTE_ON, 4'hF, 7'd127, 7'd0);
    send(KIND_NOTE_OFF, 4'hF, 7'd127, 7'd64);
    send(KIND_NOTE_ON, 4'hF, 7'd127, 7'd1);
    send(KIND_CONTROLLER, 4'hF, 7'd127, 7'd127);
    drain(SETTLE_CYCLES);

    apply_settings('{1'b1, 7'd0, 5'd0, 7'd64, 1'b0, 1'b1, 1'b1, 1'b0});
    send(KIND_NOTE_ON, 4'd0, 7'd0, 7'd127);
    send(KIND_NOTE_OFF, 4'd0, 7'd0, 7'd0);
    send(KIND_NOTE_ON, 4'd0, 7'd0, 7'd0);
    send(KIND_PITCH_BEND, 4'd0, 7'd0, 7'd0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain(SETTLE_CYCLES);
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct <= 0; end
        1: begin send_idle_pct = 61; stall_pct <= 0; end
        2: begin send_idle_pct = 0; stall_pct <= 61; end
        default: begin send_idle_pct = 11; stall_pct <= 11; end
      endcase
      if (p == 1) c = '{1'b0, 7'd127, 5'd16, 7'd127, 1'b0, 1'b1, 1'b0, 1'b1};
      else if (p == 2) c = '{1'b1, 7'd0, 5'd31, 7'd0, 1'b1, 1'b1, 1'b1, 1'b1};
      else c = random_settings();
      apply_settings(c);
      n = $urandom_range(40, 60);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2) drain(0);
        send_random(c);
      end
    end
    drain(SETTLE_CYCLES);

    $display("Run covered %0d messages across %0d register settings; %0d results compared.",
             sent_count, phase_count, results_checked);
    $display("Controller and note sources, crossing, exact match, momentary and idle mixes seen.");
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== midi_control_switch_mapper.f =====
hdl/mcsm_pkg.sv
hdl/mcsm_if.sv
hdl/mcsm_cfg_regs.sv
hdl/mcsm_map.sv
hdl/midi_control_switch_mapper.sv
hdl/mcsm_checker.sv
dv/mcsm_checker.sv
dv/tb_top.sv
